### hw/rtl/abcc_pkg.sv
// ----------------------------------------------------------------------------
// abcc_pkg: shared types and constants for the adjacent bit count counter
// Holds the table size, the modulus, the cell control group and the
// modular add used by the cells and by the final answer stage.
// ----------------------------------------------------------------------------
package abcc_pkg;

	// rows of the pair-count table, one cell per row
	localparam int MAX_BITS = 128;
	localparam int ROW_W    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

	// payload widths
	localparam int NBITS_W  = 8;
	localparam int TARGET_W = 7;
	localparam int COUNT_W  = 30;

	localparam logic [COUNT_W-1:0] MODULUS = COUNT_W'(1000000007);

	// control group broadcast to every cell
	typedef struct packed {
		logic load;   // seed the row with the length-one counts
		logic step;   // one table update for the next bit position
		logic shift;  // move every row one place toward cell 0
	} cell_ctl_t;

	// sum of two residues, reduced by one conditional subtraction
	function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
		input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, MODULUS}) begin
			sum = sum - {1'b0, MODULUS};
		end
		return sum[COUNT_W-1:0];
	endfunction

endpackage

### hw/rtl/adjacent_bit_count_counter.sv
// ----------------------------------------------------------------------------
// adjacent_bit_count_counter: counts n-bit strings with k adjacent one pairs
// Answers each query (n, k) with the count modulo 1000000007.
// ----------------------------------------------------------------------------
// One query is in flight at a time. A query with n >= 1 and k <= n-1 loads
// the row of cells, runs n-1 table updates across it (one bit position per
// cycle, all rows in parallel), shifts row k down to cell 0, then adds the
// two counts of cell 0 and hands the sum on. Queries with n = 0, or with k
// above n-1 or beyond the table, skip the table and go straight to handoff.
// The result waits in an output register; a finished query stalls only
// while that register is still full. Lengths above the table size stay
// exact and simply take more update cycles.
// ----------------------------------------------------------------------------
module adjacent_bit_count_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] num_bits, [14:8] target_count, [15] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [29:0] string_count, [31:30] zero
);

	localparam int CW = abcc_pkg::COUNT_W;
	localparam int NB = abcc_pkg::MAX_BITS;

	// controller states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_STEP   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                    state_q;
	logic [abcc_pkg::NBITS_W-1:0]  pass_cnt_q;
	logic [abcc_pkg::ROW_W-1:0]    shift_cnt_q;
	logic [CW-1:0]                 res_q;
	logic [CW-1:0]                 m_data_q;
	logic                          m_valid_q;

	logic [abcc_pkg::NBITS_W-1:0]  in_bits;
	logic [abcc_pkg::TARGET_W-1:0] in_target;
	logic                          in_beat;
	logic                          out_free;
	logic                          no_strings;
	logic                          too_big;
	abcc_pkg::cell_ctl_t           ctl;

	logic [CW-1:0] zero_row [NB];
	logic [CW-1:0] one_row  [NB];

	// input beat unpacking
	assign in_bits   = s_axis_tdata[abcc_pkg::NBITS_W-1:0];
	assign in_target = s_axis_tdata[abcc_pkg::NBITS_W +: abcc_pkg::TARGET_W];
	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;

	// short-cut queries answered without the table
	assign no_strings = (in_bits == '0);
	assign too_big    = ({1'b0, in_target} > (in_bits - 8'd1))
		|| (32'(in_target) >= NB);

	// cell control
	always_comb begin
		ctl.load  = in_beat && !no_strings && !too_big;
		ctl.step  = (state_q == ST_STEP) && (pass_cnt_q != '0);
		ctl.shift = (state_q == ST_DRAIN) && (shift_cnt_q != '0);
	end

	// row of cells, pair count 0 at index 0
	for (genvar j = 0; j < NB; j++) begin : g_cell
		logic [CW-1:0] one_below;
		logic [CW-1:0] zero_above;
		logic [CW-1:0] one_above;

		if (j == 0) begin : g_bottom
			assign one_below = '0;
		end else begin : g_mid_lo
			assign one_below = one_row[j-1];
		end

		if (j == NB - 1) begin : g_top
			assign zero_above = '0;
			assign one_above  = '0;
		end else begin : g_mid_hi
			assign zero_above = zero_row[j+1];
			assign one_above  = one_row[j+1];
		end

		abcc_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.seed       (j == 0),
			.one_below  (one_below),
			.zero_above (zero_above),
			.one_above  (one_above),
			.zero_cnt   (zero_row[j]),
			.one_cnt    (one_row[j])
		);
	end

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_cnt_q  <= '0;
			shift_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (no_strings || too_big) begin
							state_q <= ST_FINISH;
						end else begin
							state_q     <= ST_STEP;
							pass_cnt_q  <= in_bits - 8'd1;
							shift_cnt_q <= abcc_pkg::ROW_W'(in_target);
						end
					end
				end
				ST_STEP: begin
					if (pass_cnt_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						pass_cnt_q <= pass_cnt_q - 8'd1;
					end
				end
				ST_DRAIN: begin
					if (shift_cnt_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						shift_cnt_q <= shift_cnt_q - abcc_pkg::ROW_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// answer register: short-cut value or final sum of row k
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_beat) begin
			res_q <= CW'(no_strings && (in_target == '0));
		end else if (state_q == ST_DRAIN && shift_cnt_q == '0) begin
			res_q <= abcc_pkg::mod_add(zero_row[0], one_row[0]);
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == ST_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_data_q <= res_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_data_q};

`ifndef SYNTHESIS
	// one query at a time: no beat taken right after a beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_axis_tready)
		else $error("input beat accepted while a query is in flight");

	// a new result only ever comes out of the finish state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_FINISH)
		else $error("output beat raised outside the finish state");

	// results are reduced residues
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[29:0] < abcc_pkg::MODULUS)
		else $error("string_count not below the modulus");

	// update passes count down by one per cycle
	a_pass_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && pass_cnt_q != '0) |=>
		(state_q == ST_STEP && pass_cnt_q == $past(pass_cnt_q) - 8'd1))
		else $error("update pass counter skipped");

	// readout ends in the finish state
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && shift_cnt_q == '0) |=> state_q == ST_FINISH)
		else $error("readout did not reach the finish state");
`endif

endmodule

### hw/rtl/abcc_cell.sv
// ----------------------------------------------------------------------------
// abcc_cell: one row of the pair-count table
// Holds the counts of strings ending in 0 and in 1 for one pair count.
// Takes the ends-in-1 count of the row below on each update and the row
// above when the table is shifted down for readout.
// ----------------------------------------------------------------------------
module abcc_cell (
	input  logic                         clk,
	input  abcc_pkg::cell_ctl_t          ctl,
	input  logic                         seed,      // high for the row of pair count 0
	input  logic [abcc_pkg::COUNT_W-1:0] one_below, // ends-in-1 count of the row below
	input  logic [abcc_pkg::COUNT_W-1:0] zero_above,
	input  logic [abcc_pkg::COUNT_W-1:0] one_above,
	output logic [abcc_pkg::COUNT_W-1:0] zero_cnt,
	output logic [abcc_pkg::COUNT_W-1:0] one_cnt
);

	logic [abcc_pkg::COUNT_W-1:0] zero_q;
	logic [abcc_pkg::COUNT_W-1:0] one_q;

	// row update: seed, extend by one bit, or shift down
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			zero_q <= abcc_pkg::COUNT_W'(seed);
			one_q  <= abcc_pkg::COUNT_W'(seed);
		end else if (ctl.step) begin
			zero_q <= abcc_pkg::mod_add(zero_q, one_q);
			one_q  <= abcc_pkg::mod_add(zero_q, one_below);
		end else if (ctl.shift) begin
			zero_q <= zero_above;
			one_q  <= one_above;
		end
	end

	assign zero_cnt = zero_q;
	assign one_cnt  = one_q;

endmodule

### sim/string_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_count_checker: predicts and checks adjacent bit count answers
// Watches both streams, works out the expected string count for every
// accepted query and compares each returned beat with the oldest one.
// ----------------------------------------------------------------------------
module string_count_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] num_bits, [14:8] target_count, [15] zero
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [29:0] string_count, [31:30] zero
	output int          outstanding,
	output int          mismatches
);

	logic [abcc_pkg::COUNT_W-1:0] expected_counts[$];
	logic [abcc_pkg::COUNT_W-1:0] oldest_count;

	initial begin
		outstanding = 0;
		mismatches  = 0;
	end

	// residue sum, reduced with a full modulo
	function automatic logic [abcc_pkg::COUNT_W-1:0] add_residues(
		input logic [abcc_pkg::COUNT_W-1:0] a,
		input logic [abcc_pkg::COUNT_W-1:0] b);
		longint unsigned total;
		total = a;
		total = total + b;
		return abcc_pkg::COUNT_W'(total % abcc_pkg::MODULUS);
	endfunction

	// forward table pass over bit positions, rows above k never matter
	function automatic logic [abcc_pkg::COUNT_W-1:0] count_strings(
		input logic [abcc_pkg::NBITS_W-1:0] n,
		input logic [abcc_pkg::TARGET_W-1:0] k);
		logic [abcc_pkg::COUNT_W-1:0] zero_row[abcc_pkg::MAX_BITS];
		logic [abcc_pkg::COUNT_W-1:0] one_row[abcc_pkg::MAX_BITS];
		logic [abcc_pkg::COUNT_W-1:0] z, o, below;
		int len, pairs;
		len   = n;
		pairs = k;
		if (len == 0) begin
			return (pairs == 0) ? abcc_pkg::COUNT_W'(1) : '0;
		end
		if (pairs > len - 1 || pairs >= abcc_pkg::MAX_BITS) begin
			return '0;
		end
		for (int j = 0; j < abcc_pkg::MAX_BITS; j++) begin
			zero_row[j] = '0;
			one_row[j]  = '0;
		end
		// strings of length one: "0" and "1", no pairs yet
		zero_row[0] = abcc_pkg::COUNT_W'(1);
		one_row[0]  = abcc_pkg::COUNT_W'(1);
		for (int pos = 1; pos < len; pos++) begin
			// top row first so one_row[j-1] is still the old value
			for (int j = pairs; j >= 0; j--) begin
				z           = zero_row[j];
				o           = one_row[j];
				below       = (j > 0) ? one_row[j-1] : '0;
				zero_row[j] = add_residues(z, o);
				one_row[j]  = add_residues(z, below);
			end
		end
		return add_residues(zero_row[pairs], one_row[pairs]);
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		$display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// queue a prediction per query beat, check each answer beat in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_counts.push_back(count_strings(
					s_axis_tdata[abcc_pkg::NBITS_W-1:0],
					s_axis_tdata[abcc_pkg::NBITS_W+abcc_pkg::TARGET_W-1:abcc_pkg::NBITS_W]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					report_mismatch("answer beat with no query waiting", 0,
						m_axis_tdata[abcc_pkg::COUNT_W-1:0]);
				end else begin
					oldest_count = expected_counts.pop_front();
					if (m_axis_tdata[abcc_pkg::COUNT_W-1:0] !== oldest_count) begin
						report_mismatch("string_count", oldest_count,
							m_axis_tdata[abcc_pkg::COUNT_W-1:0]);
					end
				end
				if (m_axis_tdata[31:abcc_pkg::COUNT_W] !== '0) begin
					report_mismatch("answer pad bits", 0,
						m_axis_tdata[31:abcc_pkg::COUNT_W]);
				end
			end
			outstanding <= expected_counts.size();
		end
	end

endmodule

### sim/tb_adjacent_bit_count_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adjacent_bit_count_counter: stream testbench for the pair-count counter
// Sends directed corner queries, then random ones under three idling mixes,
// including a long output stall and a full drain; the checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_adjacent_bit_count_counter;

	localparam int STALL_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_QUERIES = 580;
	localparam int TAIL_CYCLES    = 16;
	localparam int NUM_DIRECTED   = 22;

	// corner queries: empty string, k past n-1, k at table edge, long strings
	localparam int DIR_N[NUM_DIRECTED] = '{
		0, 0, 0, 1, 1, 2, 2, 2, 3, 5, 64,
		100, 127, 127, 128, 128, 128, 129, 200, 255, 255, 4};
	localparam int DIR_K[NUM_DIRECTED] = '{
		0, 1, 127, 0, 1, 0, 1, 2, 1, 2, 63,
		99, 126, 127, 0, 127, 126, 127, 60, 127, 0, 85};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] num_bits, [14:8] target_count, [15] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [29:0] string_count, [31:30] zero

	int outstanding;
	int mismatches;
	int quiet_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	bit hold_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	adjacent_bit_count_counter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	string_count_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.outstanding  (outstanding),
		.mismatches   (mismatches)
	);

	// answer side: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one query, tvalid stays high afterwards unless a gap follows
	task automatic send_query(input int n, input int k);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, abcc_pkg::TARGET_W'(k), abcc_pkg::NBITS_W'(n)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// mostly well-formed k <= n-1, mostly short strings
	task automatic random_query();
		int pick, n, k, top_k;
		pick = $urandom_range(99);
		if (pick < 60) begin
			n = $urandom_range(0, 24);
		end else if (pick < 96) begin
			n = $urandom_range(25, 128);
		end else begin
			n = $urandom_range(129, 255);
		end
		top_k = (n - 1 > 127) ? 127 : n - 1;
		if (n > 0 && $urandom_range(99) < 80) begin
			k = $urandom_range(0, top_k);
		end else begin
			k = $urandom_range(0, 127);
		end
		send_query(n, k);
	endtask

	// stop offering until every answer is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		hold_req      <= 1'b0;
		send_idle_pct = 7;
		recv_idle_pct = 62;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_query(DIR_N[i], DIR_K[i]);
		end
		drain();

		// sender busy, receiver slow
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			random_query();
		end
		drain();

		// sender slow, receiver busy
		send_idle_pct = 62;
		recv_idle_pct = 7;
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			random_query();
		end
		drain();

		// no idling; long output hold while queries keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req <= ~hold_req;
		for (int i = 0; i < 20; i++) begin
			random_query();
		end
		drain();
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			random_query();
		end
		drain();

		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/abcc_pkg.sv
hw/rtl/abcc_cell.sv
hw/rtl/adjacent_bit_count_counter.sv
sim/string_count_checker.sv
sim/tb_adjacent_bit_count_counter.sv
